@@ rtl/hbp_pkg.sv @@
`default_nettype none

package hbp_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int PAD_W    = 3;
  localparam int CNT_W    = 3;
  localparam int PBITS_W  = 7;
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 16;
  localparam int MAX_OUT  = 4;
  localparam int OBCNT_W  = 3;
  localparam int ACC_W    = 40;
  localparam int TOTAL_W  = 7;

endpackage

`default_nettype wire

@@ rtl/huffman_bit_packer_unit.sv @@
// huffman_bit_packer_unit: table-driven code packer, lsb first
// input channel s_*: s_tuser carries the opcode (load, encode, flush);
//   a load writes code bits and length of one symbol into the code table,
//   an encode appends the symbol's code to the pending byte, a flush emits
//   the partial byte with its pad count and clears the pending state
// output channel m_*: one transfer per packed byte, m_tlast on the final
//   byte caused by one input item, m_tuser marks whether the byte holds data
// path to the first output byte: the table read register, then the merge
//   into the output buffer
// throughput: one item per cycle while the receiver is ready and each
//   item yields at most one byte; an encode yielding n bytes holds the
//   merge stage until the single output port drains the 4-byte result buffer
// the code table is a synchronous ram with a registered read; a load
//   followed at once by an encode of the same symbol reads the new entry
// reset clears the pending bits, the pipeline and the output buffer; the
//   code table is not cleared and must be loaded before use
// a stalled receiver holds the current byte; while the merge stage waits for
//   the buffer to drain, the input stalls as well
`default_nettype none

module huffman_bit_packer_unit
  import hbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // symbol [7:0], code_value [39:8], code_length [45:40], zero [47:46]
  input  wire logic [IN_DW-1:0]  s_tdata,
  // opcode [1:0]
  input  wire logic [1:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // out_byte [7:0], pad_bits [10:8], zero [15:11]
  output logic [OUT_DW-1:0]      m_tdata,
  // byte_valid [0]
  output logic [0:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LEN_LIM = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
  localparam int ENT_W   = CODE_W + LEN_W;

  logic [ENT_W-1:0] code_mem [NUM_SYMBOLS];

  opcode_t            in_op;
  logic [SYM_W-1:0]   in_sym;
  logic [CODE_W-1:0]  in_code;
  logic [LEN_W-1:0]   in_len;
  logic [LEN_W-1:0]   in_len_sat;
  logic [CODE_W-1:0]  in_mask;
  logic               in_sym_ok;
  logic [IDX_W-1:0]   in_idx;
  logic               in_xfer;

  logic               s1_valid;
  opcode_t            s1_op;
  logic               s1_sym_ok;
  logic [ENT_W-1:0]   rd_data;
  logic               s1_adv;

  logic [PBITS_W-1:0] pending_bits;
  logic [CNT_W-1:0]   pending_count;
  logic [PBITS_W-1:0] pending_bits_next;
  logic [CNT_W-1:0]   pending_count_next;

  logic [CODE_W-1:0]  ob_data;
  logic [OBCNT_W-1:0] ob_cnt;
  logic               ob_bvalid;
  logic [PAD_W-1:0]   ob_pad;
  logic [CODE_W-1:0]  ob_data_next;
  logic [OBCNT_W-1:0] ob_cnt_next;
  logic               ob_bvalid_next;
  logic [PAD_W-1:0]   ob_pad_next;

  logic [CODE_W-1:0]  rd_code;
  logic [LEN_W-1:0]   rd_len;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_rest;
  logic [TOTAL_W-1:0] total;
  logic [OBCNT_W-1:0] nbytes;
  logic               out_xfer;

  assign in_op     = opcode_t'(s_tuser);
  assign in_sym    = s_tdata[SYM_W-1:0];
  assign in_code   = s_tdata[SYM_W +: CODE_W];
  assign in_len    = s_tdata[SYM_W+CODE_W +: LEN_W];
  assign in_sym_ok = ({1'b0, in_sym} < (SYM_W+1)'(NUM_SYMBOLS));
  assign in_idx    = IDX_W'(in_sym);
  assign in_len_sat = (in_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : in_len;
  assign in_mask   = (in_len_sat >= LEN_W'(CODE_W)) ? {CODE_W{1'b1}}
                   : ~({CODE_W{1'b1}} << in_len_sat);

  assign out_xfer = m_tvalid && m_tready;
  assign s1_adv   = s1_valid && ((ob_cnt == '0) ||
                    ((ob_cnt == OBCNT_W'(1)) && m_tready));
  assign s_tready = !s1_valid || s1_adv;
  assign in_xfer  = s_tvalid && s_tready;

  // code table
  always_ff @(posedge clk) begin
    if (in_xfer && (in_op == OP_LOAD) && in_sym_ok) begin
      code_mem[in_idx] <= {in_len_sat, in_code & in_mask};
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= code_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op     <= in_op;
      s1_sym_ok <= in_sym_ok;
    end
  end

  // merge code into pending bits
  assign rd_code = rd_data[CODE_W-1:0];
  assign rd_len  = rd_data[CODE_W +: LEN_W];
  assign acc     = ACC_W'(pending_bits) | (ACC_W'(rd_code) << pending_count);
  assign total   = TOTAL_W'(pending_count) + TOTAL_W'(rd_len);
  assign nbytes  = (total[TOTAL_W-1:3] > 4'(MAX_OUT)) ? OBCNT_W'(MAX_OUT)
                 : OBCNT_W'(total[TOTAL_W-1:3]);
  assign acc_rest = acc >> {nbytes, 3'b000};

  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    ob_data_next       = ob_data;
    ob_cnt_next        = ob_cnt;
    ob_bvalid_next     = ob_bvalid;
    ob_pad_next        = ob_pad;
    if (out_xfer) begin
      ob_data_next = ob_data >> BYTE_W;
      ob_cnt_next  = ob_cnt - OBCNT_W'(1);
    end
    if (s1_adv) begin
      ob_cnt_next = '0;
      case (s1_op)
        OP_ENCODE: begin
          if (s1_sym_ok) begin
            ob_data_next       = acc[CODE_W-1:0];
            ob_cnt_next        = nbytes;
            ob_bvalid_next     = 1'b1;
            ob_pad_next        = '0;
            pending_bits_next  = acc_rest[PBITS_W-1:0];
            pending_count_next = total[CNT_W-1:0];
          end
        end
        OP_FLUSH: begin
          ob_data_next       = CODE_W'(pending_bits);
          ob_cnt_next        = OBCNT_W'(1);
          ob_bvalid_next     = (pending_count != '0);
          ob_pad_next        = PAD_W'(-pending_count);
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      ob_cnt        <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      ob_cnt        <= ob_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ob_data   <= ob_data_next;
    ob_bvalid <= ob_bvalid_next;
    ob_pad    <= ob_pad_next;
  end

  assign m_tvalid = (ob_cnt != '0);
  assign m_tlast  = (ob_cnt == OBCNT_W'(1));
  assign m_tdata  = {(OUT_DW-BYTE_W-PAD_W)'(0), ob_pad, ob_data[BYTE_W-1:0]};
  assign m_tuser  = ob_bvalid;

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    ob_cnt <= OBCNT_W'(MAX_OUT))
    else $error("result buffer overfilled");

  a_flush_one: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (s1_op == OP_FLUSH)) |=>
      ((ob_cnt == OBCNT_W'(1)) && (pending_count == '0) && (pending_bits == '0)))
    else $error("flush did not give one result and clear pending state");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (s1_op == OP_LOAD)) |=> (ob_cnt == '0))
    else $error("load produced a result");

  a_pipe_fill: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted item lost before merge stage");

endmodule

`default_nettype wire
